>>> hdl/lattice_message_bit_decode_core_assert.svh
// Assertion helpers shared by the decoder core and merge modules.
// Each macro expects clk and rst_n in scope.
`ifndef LATTICE_MESSAGE_BIT_DECODE_CORE_ASSERT_SVH
`define LATTICE_MESSAGE_BIT_DECODE_CORE_ASSERT_SVH

// Same-cycle implication.
`define LMBD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LMBD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/lmbd_pkg.sv
`default_nettype none

package lmbd_pkg;

    localparam int unsigned MODULUS_DEFAULT = 12289;
    localparam int unsigned COEFF_W         = 16;
    localparam int unsigned LANES           = 4;
    localparam int unsigned POS_W           = 8;
    localparam int unsigned BYTE_IDX_W      = 5;
    localparam int unsigned BIT_SEL_W       = 3;
    localparam int unsigned ADDR_W          = 3;
    localparam int unsigned DATA_W          = 32;

    // Register index of four_copies, taken from paddr[2]
    localparam logic REG_FOUR_COPIES = 1'b0;

    localparam logic [BIT_SEL_W-1:0]  LAST_BIT  = 3'd7;
    localparam logic [BYTE_IDX_W-1:0] LAST_BYTE = 5'd31;

    typedef struct packed {
        logic [COEFF_W-1:0] coeff_a;
        logic [COEFF_W-1:0] coeff_b;
        logic [COEFF_W-1:0] coeff_c;
        logic [COEFF_W-1:0] coeff_d;
    } lmbd_coef_t;

    typedef struct packed {
        logic [7:0]            msg_byte;
        logic [BYTE_IDX_W-1:0] byte_index;
        logic                  last_byte;
    } lmbd_msg_t;

    // Per-stage load enables of the lane pipeline
    typedef struct packed {
        logic ld_a;
        logic ld_b;
        logic ld_c;
    } lmbd_pipe_ctl_t;

endpackage

`default_nettype wire

>>> hdl/lattice_message_bit_decode_core.sv
// Message bit decoder for lattice KEM decapsulation.
//
// Input channel (coef_valid/coef_ready/coef): one word per message bit,
// carrying the copies at indices i, i+256, i+512 and i+768. Four lanes
// reduce each copy mod MODULUS and take its distance from MODULUS/2; a
// merge stage sums them, decides the bit and packs bits LSB first.
// Output channel (msg_valid/msg_ready/msg): one byte after every eighth
// word, with its index in the 32-byte message and a last-byte flag.
// Throughput: one word per cycle while no byte-closing word waits on a
// stalled receiver. The eighth word loads the first lane stage at the edge
// that accepts it; its byte appears after two more lane stages and the output register.
// When the receiver stalls with a byte pending, the words that close no
// byte keep flowing; the pipeline backs up only at a word that must emit.
// Reset clears the pipeline, the bit position and partial byte, and sets
// four_copies to 1. APB register at 0x0: bit 0 = four_copies (1: four
// copies, sum below Q; 0: two copies, sum below Q/2).
`default_nettype none

module lattice_message_bit_decode_core
    import lmbd_pkg::*;
#(
    parameter int unsigned MODULUS = MODULUS_DEFAULT
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              coef_valid,
    output logic                   coef_ready,
    input  wire lmbd_coef_t        coef,
    output logic                   msg_valid,
    input  wire logic              msg_ready,
    output lmbd_msg_t              msg,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    `include "lattice_message_bit_decode_core_assert.svh"

    localparam int unsigned DIST_W = $clog2(MODULUS / 2 + 1);

    logic [LANES-1:0][COEFF_W-1:0] coef_arr;
    logic [LANES-1:0][DIST_W-1:0]  lane_dist;
    lmbd_pipe_ctl_t                ctl;

    logic v_a_reg;
    logic v_b_reg;
    logic v_c_reg;
    logic rdy_a;
    logic rdy_b;
    logic rdy_c;
    logic take;
    logic four_copies_reg;
    logic four_copies_next;
    logic cfg_wr;

    assign coef_arr[0] = coef.coeff_a;
    assign coef_arr[1] = coef.coeff_b;
    assign coef_arr[2] = coef.coeff_c;
    assign coef_arr[3] = coef.coeff_d;

    // a stage loads when empty or when its contents move on
    assign rdy_c = !v_c_reg || take;
    assign rdy_b = !v_b_reg || rdy_c;
    assign rdy_a = !v_a_reg || rdy_b;

    assign ctl.ld_a = rdy_a;
    assign ctl.ld_b = rdy_b;
    assign ctl.ld_c = rdy_c;

    assign coef_ready = rdy_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a_reg <= 1'b0;
            v_b_reg <= 1'b0;
            v_c_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
            begin
                v_a_reg <= coef_valid;
            end
            if (rdy_b)
            begin
                v_b_reg <= v_a_reg;
            end
            if (rdy_c)
            begin
                v_c_reg <= v_b_reg;
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < LANES; g++)
        begin : g_lane
            lmbd_lane #(
                .MODULUS (MODULUS)
            ) u_lane (
                .clk      (clk),
                .ctl      (ctl),
                .coeff    (coef_arr[g]),
                .dist_out (lane_dist[g])
            );
        end
    endgenerate

    lmbd_merge #(
        .MODULUS (MODULUS)
    ) u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .four_copies (four_copies_reg),
        .dist_valid  (v_c_reg),
        .lane_dist   (lane_dist),
        .take        (take),
        .msg_valid   (msg_valid),
        .msg_ready   (msg_ready),
        .msg         (msg)
    );

    // APB register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        four_copies_next = four_copies_reg;
        if (cfg_wr && (paddr[2] == REG_FOUR_COPIES))
        begin
            four_copies_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            four_copies_reg <= 1'b1;
        end
        else
        begin
            four_copies_reg <= four_copies_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_FOUR_COPIES)
        begin
            prdata = DATA_W'(four_copies_reg);
        end
    end

    `LMBD_ASSERT_IMP(a_stall_cause, v_c_reg && !take, msg_valid && !msg_ready,
                     "merge stalled without a blocked output")
    `LMBD_ASSERT_NXT(a_stage_hold, v_c_reg && !take, v_c_reg, "stalled word lost")
    `LMBD_ASSERT_IMP(a_ready_chain, !coef_ready, v_a_reg && v_b_reg && v_c_reg && !take,
                     "input refused with room in the pipeline")

endmodule

`default_nettype wire

>>> hdl/lmbd_lane.sv
`default_nettype none

module lmbd_lane
    import lmbd_pkg::*;
#(
    parameter int unsigned MODULUS = MODULUS_DEFAULT,
    localparam int unsigned DIST_W = $clog2(MODULUS / 2 + 1)
)
(
    input  wire logic               clk,
    input  wire lmbd_pipe_ctl_t     ctl,
    input  wire logic [COEFF_W-1:0] coeff,
    output logic      [DIST_W-1:0]  dist_out
);

    // floor((2^32-1)/Q) is short of 2^32/Q by less than one, so the quotient
    // estimate is exact or one too small for any 16-bit input.
    localparam longint unsigned RECIP   = 64'hFFFF_FFFF / MODULUS;
    localparam int unsigned     RECIP_W = $clog2(RECIP + 1);
    localparam int unsigned     PROD_W  = COEFF_W + RECIP_W;
    localparam int unsigned     QUOT_W  = PROD_W - 32;
    localparam int unsigned     Q_W     = $clog2(MODULUS + 1);
    localparam int unsigned     HALF    = MODULUS / 2;
    localparam int unsigned     QM_W    = QUOT_W + Q_W;

    localparam logic [RECIP_W-1:0] RECIP_C  = RECIP_W'(RECIP);
    localparam logic [Q_W:0]       MOD_R    = (Q_W + 1)'(MODULUS);
    localparam logic [Q_W-1:0]     HALF_R   = Q_W'(HALF);
    localparam logic [QM_W-1:0]    MOD_M    = QM_W'(MODULUS);

    logic [PROD_W-1:0]  prod;
    logic [QUOT_W-1:0]  quot_next;
    logic [QUOT_W-1:0]  quot_reg;
    logic [COEFF_W-1:0] coef_a_reg;
    logic [QM_W-1:0]    qmul;
    logic [Q_W:0]       rem_next;
    logic [Q_W:0]       rem_reg;
    logic [Q_W-1:0]     red;
    logic [DIST_W-1:0]  dist_next;
    logic [DIST_W-1:0]  dist_reg;

    assign prod      = PROD_W'(coeff) * PROD_W'(RECIP_C);
    assign quot_next = prod[PROD_W-1:32];

    assign qmul     = QM_W'(quot_reg) * MOD_M;
    // remainder is below 2Q here
    assign rem_next = (Q_W + 1)'(coef_a_reg - COEFF_W'(qmul));

    always_comb
    begin
        if (rem_reg >= MOD_R)
        begin
            red = Q_W'(rem_reg - MOD_R);
        end
        else
        begin
            red = Q_W'(rem_reg);
        end
        if (red >= HALF_R)
        begin
            dist_next = DIST_W'(red - HALF_R);
        end
        else
        begin
            dist_next = DIST_W'(HALF_R - red);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_a)
        begin
            quot_reg   <= quot_next;
            coef_a_reg <= coeff;
        end
        if (ctl.ld_b)
        begin
            rem_reg <= rem_next;
        end
        if (ctl.ld_c)
        begin
            dist_reg <= dist_next;
        end
    end

    assign dist_out = dist_reg;

endmodule

`default_nettype wire

>>> hdl/lmbd_merge.sv
`default_nettype none

module lmbd_merge
    import lmbd_pkg::*;
#(
    parameter int unsigned MODULUS = MODULUS_DEFAULT,
    localparam int unsigned DIST_W = $clog2(MODULUS / 2 + 1)
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         four_copies,
    input  wire logic                         dist_valid,
    input  wire logic [LANES-1:0][DIST_W-1:0] lane_dist,
    output logic                              take,
    output logic                              msg_valid,
    input  wire logic                         msg_ready,
    output lmbd_msg_t                         msg
);

    `include "lattice_message_bit_decode_core_assert.svh"

    localparam int unsigned SUM_W = DIST_W + 2;
    localparam logic [SUM_W-1:0] LIM4 = SUM_W'(MODULUS);
    localparam logic [SUM_W-1:0] LIM2 = SUM_W'(MODULUS / 2);

    logic [SUM_W-1:0] sum_lo;
    logic [SUM_W-1:0] sum_all;
    logic             dec_bit;
    logic             emit;
    logic             out_free;
    logic [7:0]       bit_mask;
    logic [7:0]       merged;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       part_reg;
    logic [7:0]       part_next;
    logic             msg_valid_reg;
    logic             msg_valid_next;
    lmbd_msg_t        msg_reg;
    lmbd_msg_t        msg_next;

    assign sum_lo  = SUM_W'(lane_dist[0]) + SUM_W'(lane_dist[1]);
    assign sum_all = sum_lo + SUM_W'(lane_dist[2]) + SUM_W'(lane_dist[3]);
    assign dec_bit = four_copies ? (sum_all < LIM4) : (sum_lo < LIM2);

    assign emit     = (pos_reg[BIT_SEL_W-1:0] == LAST_BIT);
    assign out_free = !msg_valid_reg || msg_ready;
    // words that close no byte never wait on the output side
    assign take     = dist_valid && (!emit || out_free);

    assign bit_mask = 8'(dec_bit) << pos_reg[BIT_SEL_W-1:0];
    assign merged   = part_reg | bit_mask;

    always_comb
    begin
        pos_next       = pos_reg;
        part_next      = part_reg;
        msg_valid_next = msg_valid_reg && !msg_ready;
        msg_next       = msg_reg;
        if (take)
        begin
            pos_next = POS_W'(pos_reg + 1'b1);
            if (emit)
            begin
                part_next           = 8'd0;
                msg_valid_next      = 1'b1;
                msg_next.msg_byte   = merged;
                msg_next.byte_index = pos_reg[POS_W-1:BIT_SEL_W];
                msg_next.last_byte  = (pos_reg[POS_W-1:BIT_SEL_W] == LAST_BYTE);
            end
            else
            begin
                part_next = merged;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            part_reg      <= '0;
            msg_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            part_reg      <= part_next;
            msg_valid_reg <= msg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        msg_reg <= msg_next;
    end

    assign msg_valid = msg_valid_reg;
    assign msg       = msg_reg;

    `LMBD_ASSERT_NXT(a_emit_shows, take && emit, msg_valid_reg, "closed byte not presented")
    `LMBD_ASSERT_NXT(a_pos_step, take, pos_reg == POS_W'($past(pos_reg) + 1'b1),
                     "bit position did not advance")
    `LMBD_ASSERT_NXT(a_part_clear, take && emit, part_reg == 8'd0,
                     "partial byte not cleared after emit")

endmodule

`default_nettype wire

>>> sim/lattice_message_bit_decode_core_tb.sv
`default_nettype none

module lattice_message_bit_decode_core_tb
    import lmbd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MODULUS        = MODULUS_DEFAULT;
    localparam int unsigned HALF_Q         = MODULUS / 2;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned LONG_STALL     = 400;
    localparam int unsigned WATCHDOG_LIMIT = 4000;

    localparam logic [ADDR_W-1:0] ADDR_FOUR_COPIES = {REG_FOUR_COPIES, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_UNMAPPED    = {~REG_FOUR_COPIES, 2'b00};

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              coef_valid = 1'b0;
    logic              coef_ready;
    lmbd_coef_t        coef       = '0;
    logic              msg_valid;
    logic              msg_ready  = 1'b0;
    lmbd_msg_t         msg;
    logic              psel       = 1'b0;
    logic              penable    = 1'b0;
    logic              pwrite     = 1'b0;
    logic [ADDR_W-1:0] paddr      = '0;
    logic [DATA_W-1:0] pwdata     = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    lmbd_coef_t  coef_pend[$];
    lmbd_msg_t   byte_expect[$];
    lmbd_msg_t   want;

    // decoder state mirrored by the testbench
    logic             four_copies_cfg = 1'b1;
    logic [POS_W-1:0] dec_pos         = '0;
    logic [7:0]       dec_acc         = '0;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          stall_reqs    = 0;
    int          stall_seen    = 0;
    int          stall_left    = 0;
    int          quiet_cycles  = 0;
    int          fail_count    = 0;

    lattice_message_bit_decode_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .coef_valid(coef_valid),
        .coef_ready(coef_ready),
        .coef      (coef),
        .msg_valid (msg_valid),
        .msg_ready (msg_ready),
        .msg       (msg),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int unsigned center_distance(logic [COEFF_W-1:0] raw);
        int unsigned r;
        r = int'(raw) % MODULUS;
        if (r >= HALF_Q)
            return r - HALF_Q;
        return HALF_Q - r;
    endfunction

    function automatic logic decode_bit(lmbd_coef_t w, logic four);
        int unsigned total;
        total = center_distance(w.coeff_a) + center_distance(w.coeff_b);
        if (four)
        begin
            total = total + center_distance(w.coeff_c) + center_distance(w.coeff_d);
            return total < MODULUS;
        end
        return total < HALF_Q;
    endfunction

    // bias toward residues near zero and near Q/2, plus the band above 5Q
    function automatic logic [COEFF_W-1:0] pick_coeff();
        int unsigned lap;
        lap = $urandom_range(4);
        case ($urandom_range(7))
            0: return COEFF_W'(lap * MODULUS + HALF_Q - 8 + $urandom_range(16));
            1: return COEFF_W'(lap * MODULUS + $urandom_range(8));
            2: return COEFF_W'((lap + 1) * MODULUS - 1 - $urandom_range(8));
            3: return COEFF_W'(65535 - $urandom_range(65535 - 5 * MODULUS));
            default: return COEFF_W'($urandom);
        endcase
    endfunction

    task automatic push_word(input logic [COEFF_W-1:0] a, b, c, d);
        coef_pend.push_back('{coeff_a: a, coeff_b: b, coeff_c: c, coeff_d: d});
    endtask

    task automatic push_random(input int count);
        @(negedge clk);
        repeat (count)
            coef_pend.push_back('{pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff()});
        while (coef_pend.size() != 0)
            @(negedge clk);
    endtask

    // hold the sender until every byte has come, then let words still in flight settle
    task automatic wait_drained();
        while (coef_pend.size() != 0 || coef_valid || byte_expect.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data, output logic [DATA_W-1:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_config(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        logic [DATA_W-1:0] rd;
        apb_access(1'b1, addr, data, rd);
        if (addr[ADDR_W-1] == REG_FOUR_COPIES)
            four_copies_cfg <= data[0];
        apb_access(1'b0, ADDR_FOUR_COPIES, '0, rd);
        if (rd !== DATA_W'(four_copies_cfg))
        begin
            $display("%0t: four_copies readback mismatch, expected %08h, got %08h",
                     $time, DATA_W'(four_copies_cfg), rd);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            coef_valid <= 1'b0;
        else if (!coef_valid || coef_ready)
        begin
            if (coef_pend.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                coef       <= coef_pend.pop_front();
                coef_valid <= 1'b1;
            end
            else
                coef_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            msg_ready  <= 1'b0;
        end
        else if (stall_seen != stall_reqs)
        begin
            stall_seen <= stall_reqs;
            stall_left <= LONG_STALL;
            msg_ready  <= 1'b0;
        end
        else
            msg_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // predict: pack one decoded bit per accepted word, emit on the eighth
    always @(posedge clk)
    begin
        if (rst_n && coef_valid && coef_ready)
        begin
            dec_acc[dec_pos[BIT_SEL_W-1:0]] = decode_bit(coef, four_copies_cfg);
            if (dec_pos[BIT_SEL_W-1:0] == LAST_BIT)
            begin
                byte_expect.push_back('{msg_byte:   dec_acc,
                                        byte_index: dec_pos[POS_W-1:BIT_SEL_W],
                                        last_byte:  dec_pos[POS_W-1:BIT_SEL_W] == LAST_BYTE});
                dec_acc = '0;
            end
            dec_pos = dec_pos + 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && msg_valid && msg_ready)
        begin
            if (byte_expect.size() == 0)
            begin
                $display("%0t: unexpected byte, expected none, got %02h index %0d last %0b",
                         $time, msg.msg_byte, msg.byte_index, msg.last_byte);
                fail_count++;
            end
            else
            begin
                want = byte_expect.pop_front();
                if (msg.msg_byte !== want.msg_byte)
                begin
                    $display("%0t: msg_byte mismatch, expected %02h, got %02h",
                             $time, want.msg_byte, msg.msg_byte);
                    fail_count++;
                end
                if (msg.byte_index !== want.byte_index)
                begin
                    $display("%0t: byte_index mismatch, expected %0d, got %0d",
                             $time, want.byte_index, msg.byte_index);
                    fail_count++;
                end
                if (msg.last_byte !== want.last_byte)
                begin
                    $display("%0t: last_byte mismatch, expected %0b, got %0b",
                             $time, want.last_byte, msg.last_byte);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((coef_valid && coef_ready) || (msg_valid && msg_ready) || psel)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int phase;

        repeat (2)
            @(posedge clk);
        rst_n         <= 1'b1;
        send_idle_pct <= 14;
        recv_idle_pct <= 46;

        // four copies, reset mode: extremes and both sides of the Q threshold
        @(negedge clk);
        push_word(16'd0,     16'd0,     16'd0,     16'd0);
        push_word(16'd6144,  16'd6144,  16'd6144,  16'd6144);
        push_word(16'd65535, 16'd65535, 16'd65535, 16'd65535);
        push_word(16'd12289, 16'd24578, 16'd36867, 16'd49156);
        push_word(16'd0,     16'd12288, 16'd6145,  16'd6144);
        push_word(16'd0,     16'd12288, 16'd6144,  16'd6144);
        push_word(16'd55300, 16'd55300, 16'd55300, 16'd55300);
        push_word(16'd61444, 16'd61445, 16'd1,     16'd12287);
        push_word(16'd18433, 16'd6143,  16'd6144,  16'd6144);
        push_word(16'd65535, 16'd0,     16'd0,     16'd0);
        push_word(16'd6144,  16'd6144,  16'd0,     16'd0);
        push_word(16'd6143,  16'd6145,  16'd6143,  16'd6145);
        wait_drained();

        // switch to two copies mid-byte; high bits dropped, unmapped write ignored
        write_config(ADDR_FOUR_COPIES, 32'hFFFF_FFFE);
        write_config(ADDR_UNMAPPED, 32'h0000_0001);
        @(negedge clk);
        push_word(16'd0,     16'd6144,  16'd6144,  16'd6144);
        push_word(16'd1,     16'd6144,  16'd0,     16'd0);
        push_word(16'd6144,  16'd6144,  16'd65535, 16'd65535);
        push_word(16'd65535, 16'd65535, 16'd0,     16'd0);
        push_word(16'd0,     16'd0,     16'd6144,  16'd6144);
        push_word(16'd12287, 16'd6144,  16'd0,     16'd0);
        push_word(16'd12288, 16'd12289, 16'd6144,  16'd6144);
        push_word(16'd43011, 16'd43011, 16'd0,     16'd0);
        push_word(16'd6145,  16'd12288, 16'd6144,  16'd6144);
        push_word(16'd6144,  16'd12287, 16'd0,     16'd0);
        push_word(16'd65535, 16'd6144,  16'd0,     16'd0);
        push_word(16'd0,     16'd65535, 16'd6144,  16'd6144);
        wait_drained();
        write_config(ADDR_FOUR_COPIES, 32'hFFFF_FFFF);

        // hold off the receiver while words keep coming so the pipeline backs up
        @(posedge clk);
        stall_reqs <= stall_reqs + 1;
        push_random(120);
        wait_drained();

        for (phase = 0; phase < 3; phase++)
        begin
            @(negedge clk);
            send_idle_pct <= (phase == 0) ? 14 : (phase == 1) ? 46 : 0;
            recv_idle_pct <= (phase == 0) ? 46 : (phase == 1) ? 14 : 0;
            repeat (4)
            begin
                push_random($urandom_range(1, 110));
                wait_drained();
                if ($urandom_range(7) == 0)
                    write_config(ADDR_UNMAPPED, DATA_W'($urandom));
                else
                    write_config(ADDR_FOUR_COPIES,
                                 {(DATA_W - 1)'($urandom), 1'($urandom_range(1))});
            end
        end

        wait_drained();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
+incdir+hdl
hdl/lmbd_pkg.sv
hdl/lmbd_lane.sv
hdl/lmbd_merge.sv
hdl/lattice_message_bit_decode_core.sv
sim/lattice_message_bit_decode_core_tb.sv
